FILE: rtl/core/sdnr_pkg.sv
// Shared types, constants and pitch-class helpers for the scale degree note remapper.
// No dependencies; imported by sdnr_cell, sdnr_rebuild and scale_degree_note_remapper.
package sdnr_pkg;

  // Fixed field widths
  localparam int unsigned PITCH_W   = 7;
  localparam int unsigned CLASS_W   = 4;
  localparam int unsigned CLASSES_W = 48;
  localparam int unsigned CFG_IDX_W = 3;

  // Default number of degree cells
  localparam int unsigned MAX_DEGREES_DEF = 12;

  // Pitch classes per octave and the centred-distance bounds
  localparam int unsigned OCTAVE   = 12;
  localparam int unsigned DIST_MAX = 6;
  // Marker above any real distance, loaded before the first cell
  localparam logic [2:0]  DIST_NONE = 3'd7;

  // Register reset values (C major, key of C, seven degrees)
  localparam logic [CLASS_W-1:0]   KEY_RST     = 4'd0;
  localparam logic [CLASSES_W-1:0] CLASSES_RST = 48'h0000_0B97_5420;
  localparam logic [CLASS_W-1:0]   SIZE_RST    = 4'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_KEY     = 3'd0,
    CFG_SOURCE_CLASSES = 3'd1,
    CFG_SOURCE_SIZE    = 3'd2,
    CFG_TARGET_KEY     = 3'd3,
    CFG_TARGET_CLASSES = 3'd4,
    CFG_TARGET_SIZE    = 3'd5
  } cfg_idx_e;

  // Token carried along the row of degree cells
  typedef struct packed {
    logic                 valid;
    logic [CLASS_W-1:0]   pc;       // pitch class of the note
    logic signed [8:0]    root;     // source root at or below the note
    logic [CLASS_W-1:0]   idx;      // best degree so far
    logic signed [3:0]    alt;      // alteration of the best degree
    logic [2:0]           distance; // distance of the best degree
  } sdnr_token_t;

  // Reduce a nibble modulo 12
  function automatic logic [CLASS_W-1:0] red12(logic [CLASS_W-1:0] v);
    return (v >= 4'(OCTAVE)) ? v - 4'(OCTAVE) : v;
  endfunction

  // Centred difference to - from, wrapped into -6..6
  function automatic logic signed [4:0] centre_delta(logic [CLASS_W-1:0] from_pc,
                                                     logic [CLASS_W-1:0] to_pc);
    logic signed [4:0] d;
    d = $signed({1'b0, to_pc}) - $signed({1'b0, from_pc});
    if (d > $signed(5'(DIST_MAX))) begin
      d = d - $signed(5'(OCTAVE));
    end else if (d < -$signed(5'(DIST_MAX))) begin
      d = d + $signed(5'(OCTAVE));
    end
    return d;
  endfunction

  // Non-negative residue of a difference of two pitch classes
  function automatic logic [CLASS_W-1:0] up_mod12(logic [CLASS_W-1:0] a,
                                                  logic [CLASS_W-1:0] b);
    logic signed [4:0] d;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    if (d < 5'sd0) begin
      d = d + $signed(5'(OCTAVE));
    end
    return d[CLASS_W-1:0];
  endfunction

endpackage

FILE: rtl/core/sdnr_cell.sv
// One degree cell: compares the note with a single source degree and keeps the nearer one.
// Depends on sdnr_pkg.
module sdnr_cell
  import sdnr_pkg::*;
#(
  parameter int unsigned DegreeIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CLASS_W-1:0] degree_class_i,
  input  logic               degree_used_i,
  input  sdnr_token_t        token_i,
  output sdnr_token_t        token_o
);

  logic signed [4:0] delta;
  logic [2:0]        distance;
  logic              better;
  sdnr_token_t       token_d;
  sdnr_token_t       token_q;

  // Distance of the note from this degree; lower index wins ties
  always_comb begin
    delta    = centre_delta(degree_class_i, token_i.pc);
    distance = (delta < 5'sd0) ? 3'(-delta) : delta[2:0];
    better   = degree_used_i && (distance < token_i.distance);
  end

  // Take over the best degree when this one is nearer
  always_comb begin
    token_d = token_i;
    if (better) begin
      token_d.idx      = CLASS_W'(DegreeIdx);
      token_d.alt      = delta[3:0];
      token_d.distance = distance;
    end
  end

  // Clear the token under reset, advance it every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else begin
      token_q <= token_d;
    end
  end

  assign token_o = token_q;

endmodule

FILE: rtl/core/sdnr_rebuild.sv
// Final stage: clamps the degree to the target scale, rebuilds and saturates the note.
// Depends on sdnr_pkg.
module sdnr_rebuild
  import sdnr_pkg::*;
#(
  parameter int unsigned MaxDegrees = MAX_DEGREES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdnr_token_t          token_i,
  input  logic [CLASS_W-1:0]   source_key_i,
  input  logic [CLASS_W-1:0]   target_key_i,
  input  logic [CLASS_W-1:0]   target_class_i [MaxDegrees],
  input  logic [CLASS_W-1:0]   target_size_i,
  output logic                 result_valid_o,
  output logic [CLASS_W-1:0]   degree_index_o,
  output logic signed [3:0]    alteration_o,
  output logic                 is_accidental_o,
  output logic [PITCH_W-1:0]   mapped_pitch_o,
  output logic                 saturated_o
);

  logic [CLASS_W-1:0] tidx;
  logic [CLASS_W-1:0] tclass;
  logic signed [4:0]  shift;
  logic [CLASS_W-1:0] interval;
  logic signed [8:0]  sum;
  logic [PITCH_W-1:0] pitch_d;
  logic               sat_d;

  logic               valid_q;
  logic [CLASS_W-1:0] idx_q;
  logic signed [3:0]  alt_q;
  logic [PITCH_W-1:0] pitch_q;
  logic               sat_q;

  // Clamp the degree and pick the target class
  always_comb begin
    tidx   = (token_i.idx < target_size_i) ? token_i.idx : target_size_i - 4'd1;
    tclass = '0;
    for (int j = 0; j < MaxDegrees; j++) begin
      if (tidx == CLASS_W'(j)) begin
        tclass = target_class_i[j];
      end
    end
  end

  // Rebuild the note and saturate into the MIDI range
  always_comb begin
    shift    = centre_delta(source_key_i, target_key_i);
    interval = up_mod12(tclass, target_key_i);
    sum      = token_i.root + 9'(shift) + $signed({5'b0, interval}) + 9'(token_i.alt);
    if (sum < 9'sd0) begin
      pitch_d = '0;
      sat_d   = 1'b1;
    end else if (sum > 9'sd127) begin
      pitch_d = '1;
      sat_d   = 1'b1;
    end else begin
      pitch_d = sum[PITCH_W-1:0];
      sat_d   = 1'b0;
    end
  end

  // Strobe for one cycle per note
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= token_i.valid;
    end
  end

  // Register the result fields
  always_ff @(posedge clk_i) begin
    idx_q   <= token_i.idx;
    alt_q   <= token_i.alt;
    pitch_q <= pitch_d;
    sat_q   <= sat_d;
  end

  assign result_valid_o  = valid_q;
  assign degree_index_o  = idx_q;
  assign alteration_o    = alt_q;
  assign is_accidental_o = (alt_q != 4'sd0);
  assign mapped_pitch_o  = pitch_q;
  assign saturated_o     = sat_q;

endmodule

FILE: rtl/core/scale_degree_note_remapper.sv
// Top level of the scale degree note remapper: config registers, entry stage, cell row, rebuild stage.
// Depends on sdnr_pkg, sdnr_cell and sdnr_rebuild.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+------------------------------------
//   note      | in        | start, busy               | note_pitch_i
//   result    | out       | result_valid_o (strobe)   | degree_index_o, alteration_o,
//             |           |                           | is_accidental_o, mapped_pitch_o,
//             |           |                           | saturated_o
//   config    | in        | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One note is taken every cycle; busy stays low. Each note passes one entry stage, one cell
// per degree slot and one rebuild stage on its way to the result.
// The length of the cell row sets the latency; throughput is one note per cycle.
// Reset clears the pipeline valid flags and loads C major in the key of C for both scales.
// The receiver cannot stall, so results leave on their strobe cycle.
module scale_degree_note_remapper
  import sdnr_pkg::*;
#(
  parameter int unsigned MaxDegrees = MAX_DEGREES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [PITCH_W-1:0]     note_pitch_i,
  output logic                   result_valid_o,
  output logic [CLASS_W-1:0]     degree_index_o,
  output logic signed [3:0]      alteration_o,
  output logic                   is_accidental_o,
  output logic [PITCH_W-1:0]     mapped_pitch_o,
  output logic                   saturated_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CLASSES_W-1:0]   cfg_data_i
);

  logic [CLASS_W-1:0]   source_key_q;
  logic [CLASSES_W-1:0] source_classes_q;
  logic [CLASS_W-1:0]   source_size_q;
  logic [CLASS_W-1:0]   target_key_q;
  logic [CLASSES_W-1:0] target_classes_q;
  logic [CLASS_W-1:0]   target_size_q;

  logic [CLASS_W-1:0]   skey;
  logic [CLASS_W-1:0]   tkey;
  logic [CLASS_W-1:0]   ssize;
  logic [CLASS_W-1:0]   tsize;
  logic [CLASS_W-1:0]   src_class [MaxDegrees];
  logic [CLASS_W-1:0]   tgt_class [MaxDegrees];
  logic                 src_used  [MaxDegrees];

  logic                 accept;
  logic [14:0]          quot_prod;
  logic [CLASS_W-1:0]   quot;
  logic [PITCH_W-1:0]   note_pc;
  logic [CLASS_W-1:0]   below_root;
  sdnr_token_t          entry_d;
  sdnr_token_t          entry_q;
  sdnr_token_t          chain [MaxDegrees+1];

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;
  assign accept      = start && !busy;

  // Write the addressed configuration register on each config transaction; indexes 6 and 7 write nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_key_q     <= KEY_RST;
      source_classes_q <= CLASSES_RST;
      source_size_q    <= SIZE_RST;
      target_key_q     <= KEY_RST;
      target_classes_q <= CLASSES_RST;
      target_size_q    <= SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SOURCE_KEY:     source_key_q     <= cfg_data_i[CLASS_W-1:0];
        CFG_SOURCE_CLASSES: source_classes_q <= cfg_data_i;
        CFG_SOURCE_SIZE:    source_size_q    <= cfg_data_i[CLASS_W-1:0];
        CFG_TARGET_KEY:     target_key_q     <= cfg_data_i[CLASS_W-1:0];
        CFG_TARGET_CLASSES: target_classes_q <= cfg_data_i;
        CFG_TARGET_SIZE:    target_size_q    <= cfg_data_i[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Reduce keys, limit sizes; an empty target scale uses its first degree
  always_comb begin
    skey  = red12(source_key_q);
    tkey  = red12(target_key_q);
    ssize = (source_size_q > CLASS_W'(MaxDegrees)) ? CLASS_W'(MaxDegrees) : source_size_q;
    tsize = (target_size_q > CLASS_W'(MaxDegrees)) ? CLASS_W'(MaxDegrees) : target_size_q;
    if (tsize == '0) begin
      tsize = 4'd1;
    end
  end

  // Unpack per-degree classes, reduced modulo 12
  for (genvar g = 0; g < MaxDegrees; g++) begin : g_unpack
    assign src_class[g] = red12(source_classes_q[CLASS_W*g +: CLASS_W]);
    assign tgt_class[g] = red12(target_classes_q[CLASS_W*g +: CLASS_W]);
    assign src_used[g]  = (CLASS_W'(g) < ssize);
  end

  // Entry stage: pitch class by reciprocal multiply, source root at or below the note
  always_comb begin
    quot_prod  = 15'(note_pitch_i) * 15'd171;
    quot       = quot_prod[14:11];
    note_pc    = note_pitch_i - (7'(quot) * 7'd12);
    below_root = up_mod12(note_pc[CLASS_W-1:0], skey);
    entry_d.valid    = accept;
    entry_d.pc       = note_pc[CLASS_W-1:0];
    entry_d.root     = $signed({2'b00, note_pitch_i}) - $signed({5'b0, below_root});
    entry_d.idx      = '0;
    entry_d.alt      = '0;
    entry_d.distance = DIST_NONE;
  end

  // Clear the entry token under reset, advance it every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  // Row of degree cells, one per degree slot; slots beyond the source size pass the token on
  for (genvar c = 0; c < MaxDegrees; c++) begin : g_cell
    sdnr_cell #(
      .DegreeIdx (c)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .degree_class_i (src_class[c]),
      .degree_used_i  (src_used[c]),
      .token_i        (chain[c]),
      .token_o        (chain[c+1])
    );
  end

  // Rebuild the note in the target key
  sdnr_rebuild #(
    .MaxDegrees (MaxDegrees)
  ) u_rebuild (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .token_i         (chain[MaxDegrees]),
    .source_key_i    (skey),
    .target_key_i    (tkey),
    .target_class_i  (tgt_class),
    .target_size_i   (tsize),
    .result_valid_o  (result_valid_o),
    .degree_index_o  (degree_index_o),
    .alteration_o    (alteration_o),
    .is_accidental_o (is_accidental_o),
    .mapped_pitch_o  (mapped_pitch_o),
    .saturated_o     (saturated_o)
  );

endmodule
